>>> rtl/tcw_pkg.sv
`default_nettype none

package tcw_pkg;

  // Default screen geometry
  localparam int SCREEN_COLS_DEF = 80;
  localparam int SCREEN_ROWS_DEF = 25;

  // Field widths of the words on the ports
  localparam int KIND_W  = 1;
  localparam int CHAR_W  = 8;
  localparam int ROW_W   = 5;
  localparam int COL_W   = 7;
  localparam int BYTE_W  = 8;
  localparam int CELL_W  = 16;

  localparam logic [BYTE_W-1:0] TEXT_COLOR_RESET = 8'h07;
  localparam logic [CELL_W-1:0] CLEAR_CELL       = 16'h0720;

  localparam logic [CHAR_W-1:0] CH_NEWLINE    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_SPACE      = 8'h20;
  localparam logic [CHAR_W-1:0] CH_QUOTE      = 8'h27;
  localparam logic [CHAR_W-1:0] CH_COLON      = 8'h3A;
  localparam logic [CHAR_W-1:0] CH_BACKSLASH  = 8'h5C;
  localparam logic [CHAR_W-1:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [CHAR_W-1:0] CH_DIGIT_0    = 8'h30;
  localparam logic [CHAR_W-1:0] CH_DIGIT_9    = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UPPER_A    = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UPPER_Z    = 8'h5A;
  localparam logic [CHAR_W-1:0] CH_LOWER_A    = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LOWER_Z    = 8'h7A;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUT  = 1'b0,
    KIND_READ = 1'b1
  } tcw_kind_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_PUT,
    ST_SCROLL,
    ST_FILL,
    ST_DONE
  } tcw_state_e;

  typedef struct packed {
    tcw_kind_e         kind;
    logic [CHAR_W-1:0] char_code;
    logic [ROW_W-1:0]  read_row;
    logic [COL_W-1:0]  read_col;
  } tcw_item_t;

  typedef struct packed {
    logic [ROW_W-1:0]  cursor_row;
    logic [COL_W-1:0]  cursor_col;
    logic [BYTE_W-1:0] cell_glyph;
    logic [BYTE_W-1:0] cell_color;
  } tcw_result_t;

  // Glyphs that one put word expands to
  typedef struct packed {
    logic                    newline;
    logic [1:0]              count;
    logic [2:0][CHAR_W-1:0]  glyph;
  } tcw_seq_t;

endpackage

`default_nettype wire

>>> rtl/tcw_if.sv
`default_nettype none

interface tcw_item_if import tcw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [CHAR_W-1:0] char_code;
  logic [ROW_W-1:0]  read_row;
  logic [COL_W-1:0]  read_col;

  modport source (output valid, kind, char_code, read_row, read_col, input ready);
  modport sink   (input valid, kind, char_code, read_row, read_col, output ready);
endinterface

interface tcw_result_if import tcw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ROW_W-1:0]  cursor_row;
  logic [COL_W-1:0]  cursor_col;
  logic [BYTE_W-1:0] cell_glyph;
  logic [BYTE_W-1:0] cell_color;

  modport source (output valid, cursor_row, cursor_col, cell_glyph, cell_color, input ready);
  modport sink   (input valid, cursor_row, cursor_col, cell_glyph, cell_color, output ready);
endinterface

interface tcw_cfg_if import tcw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] text_color;

  modport source (output valid, text_color, input ready);
  modport sink   (input valid, text_color, output ready);
endinterface

`default_nettype wire

>>> rtl/tcw_glyph_encoder.sv
`default_nettype none

module tcw_glyph_encoder import tcw_pkg::*; (
  input  logic [CHAR_W-1:0] char_i,
  output tcw_seq_t          seq_o
);

  function automatic logic [CHAR_W-1:0] hex_digit(input logic [3:0] nib);
    logic [CHAR_W-1:0] r;
    if (nib < 4'd10) begin
      r = CH_DIGIT_0 + CHAR_W'(nib);
    end else begin
      r = CH_UPPER_A + CHAR_W'(nib - 4'd10);
    end
    return r;
  endfunction

  logic plain;

  assign plain = ((char_i >= CH_LOWER_A) && (char_i <= CH_LOWER_Z)) ||
                 ((char_i >= CH_UPPER_A) && (char_i <= CH_UPPER_Z)) ||
                 ((char_i >= CH_DIGIT_0) && (char_i <= CH_DIGIT_9)) ||
                 (char_i == CH_BACKSLASH) || (char_i == CH_SPACE) ||
                 (char_i == CH_QUOTE) || (char_i == CH_COLON) ||
                 (char_i == CH_UNDERSCORE);

  always_comb begin
    seq_o.newline = 1'b0;
    seq_o.count   = 2'd1;
    seq_o.glyph   = '0;
    if (char_i == CH_NEWLINE) begin
      seq_o.newline = 1'b1;
      seq_o.count   = 2'd0;
    end else if (plain) begin
      seq_o.glyph[0] = char_i;
    end else begin
      // Unprintable bytes are shown as a backslash and two hex digits.
      seq_o.count    = 2'd3;
      seq_o.glyph[0] = CH_BACKSLASH;
      seq_o.glyph[1] = hex_digit(char_i[7:4]);
      seq_o.glyph[2] = hex_digit(char_i[3:0]);
    end
  end

endmodule

`default_nettype wire

>>> rtl/tcw_engine.sv
`default_nettype none

module tcw_engine import tcw_pkg::*; #(
  parameter int ScreenCols = SCREEN_COLS_DEF,
  parameter int ScreenRows = SCREEN_ROWS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  tcw_item_t         item_i,
  input  tcw_seq_t          seq_i,
  input  logic [BYTE_W-1:0] color_i,
  input  logic              res_taken_i,
  output logic              idle_o,
  output logic              res_valid_o,
  output tcw_result_t       res_o
);

  localparam int Total = ScreenRows * ScreenCols;
  localparam int AW    = $clog2(Total);
  localparam int CW    = $clog2(Total + 1);
  localparam int RW    = $clog2(ScreenRows);
  localparam int LW    = $clog2(ScreenCols);

  tcw_state_e state_q, state_d;
  logic [RW-1:0]     row_q, row_d;
  logic [LW-1:0]     col_q, col_d;
  logic [1:0]        idx_q, idx_d;
  tcw_seq_t          seq_q, seq_d;
  logic [CW-1:0]     scr_q, scr_d;
  logic [AW-1:0]     wr_q, wr_d;
  logic              pend_q, pend_d;
  logic [BYTE_W-1:0] glyph_q, glyph_d;
  logic [BYTE_W-1:0] color_q, color_d;

  logic [CELL_W-1:0] screen_q [Total];
  logic [CELL_W-1:0] rdata_q;
  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [CELL_W-1:0] mem_wdata;

  logic [AW-1:0] cur_addr, rd_addr;
  logic          in_range, row_last, col_last, seq_last;
  logic [31:0]   row_wide, col_wide;

  assign cur_addr = AW'(row_q) * AW'(ScreenCols) + AW'(col_q);
  assign rd_addr  = AW'(item_i.read_row) * AW'(ScreenCols) + AW'(item_i.read_col);
  assign in_range = (32'(item_i.read_row) < 32'(ScreenRows)) &&
                    (32'(item_i.read_col) < 32'(ScreenCols));
  assign row_last = (row_q == RW'(ScreenRows - 1));
  assign col_last = (col_q == LW'(ScreenCols - 1));
  assign seq_last = ((idx_q + 2'd1) == seq_q.count);

  always_comb begin
    state_d   = state_q;
    row_d     = row_q;
    col_d     = col_q;
    idx_d     = idx_q;
    seq_d     = seq_q;
    scr_d     = scr_q;
    wr_d      = wr_q;
    pend_d    = 1'b0;
    glyph_d   = glyph_q;
    color_d   = color_q;
    mem_we    = 1'b0;
    mem_waddr = wr_q;
    mem_wdata = CLEAR_CELL;
    mem_re    = 1'b0;
    mem_raddr = scr_q[AW-1:0];
    case (state_q)
      ST_CLEAR: begin
        mem_we = 1'b1;
        if (wr_q == AW'(Total - 1)) begin
          wr_d    = '0;
          state_d = ST_IDLE;
        end else begin
          wr_d = wr_q + 1'b1;
        end
      end
      ST_IDLE: begin
        if (start_i) begin
          glyph_d = '0;
          color_d = '0;
          idx_d   = '0;
          seq_d   = seq_i;
          if (item_i.kind == KIND_READ) begin
            if (in_range) begin
              mem_re    = 1'b1;
              mem_raddr = rd_addr;
              state_d   = ST_READ;
            end else begin
              state_d = ST_DONE;
            end
          end else if (seq_i.newline) begin
            col_d = '0;
            if (row_last) begin
              scr_d   = CW'(ScreenCols);
              wr_d    = '0;
              state_d = ST_SCROLL;
            end else begin
              row_d   = row_q + 1'b1;
              state_d = ST_DONE;
            end
          end else begin
            state_d = ST_PUT;
          end
        end
      end
      ST_READ: begin
        glyph_d = rdata_q[BYTE_W-1:0];
        color_d = rdata_q[CELL_W-1:BYTE_W];
        state_d = ST_DONE;
      end
      ST_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = cur_addr;
        mem_wdata = {color_i, seq_q.glyph[idx_q]};
        idx_d     = idx_q + 2'd1;
        if (col_last) begin
          col_d = '0;
          if (row_last) begin
            scr_d   = CW'(ScreenCols);
            wr_d    = '0;
            state_d = ST_SCROLL;
          end else begin
            row_d   = row_q + 1'b1;
            state_d = seq_last ? ST_DONE : ST_PUT;
          end
        end else begin
          col_d   = col_q + 1'b1;
          state_d = seq_last ? ST_DONE : ST_PUT;
        end
      end
      ST_SCROLL: begin
        // Reads run one row ahead of the writes, so a row is never
        // overwritten before it has been read.
        if (pend_q) begin
          mem_we    = 1'b1;
          mem_wdata = rdata_q;
          wr_d      = wr_q + 1'b1;
        end
        if (scr_q != CW'(Total)) begin
          mem_re = 1'b1;
          scr_d  = scr_q + 1'b1;
          pend_d = 1'b1;
        end else begin
          state_d = ST_FILL;
        end
      end
      ST_FILL: begin
        mem_we    = 1'b1;
        mem_wdata = {color_i, CH_SPACE};
        if (wr_q == AW'(Total - 1)) begin
          state_d = (idx_q == seq_q.count) ? ST_DONE : ST_PUT;
        end else begin
          wr_d = wr_q + 1'b1;
        end
      end
      ST_DONE: begin
        if (res_taken_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      row_q   <= '0;
      col_q   <= '0;
      idx_q   <= '0;
      wr_q    <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
      col_q   <= col_d;
      idx_q   <= idx_d;
      wr_q    <= wr_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    seq_q   <= seq_d;
    scr_q   <= scr_d;
    glyph_q <= glyph_d;
    color_q <= color_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      screen_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= screen_q[mem_raddr];
    end
  end

  assign row_wide = 32'(row_q);
  assign col_wide = 32'(col_q);

  assign idle_o           = (state_q == ST_IDLE);
  assign res_valid_o      = (state_q == ST_DONE);
  assign res_o.cursor_row = row_wide[ROW_W-1:0];
  assign res_o.cursor_col = col_wide[COL_W-1:0];
  assign res_o.cell_glyph = glyph_q;
  assign res_o.cell_color = color_q;

endmodule

`default_nettype wire

>>> rtl/text_console_writer_unit.sv
// Text console engine: a screen store of ScreenRows x ScreenCols 16-bit cells (glyph in the
// low byte, colour in the high byte) and a cursor. After reset the store is cleared to
// spaces in colour 7, during which no word is taken on item_i; colour writes on cfg_i are
// always taken. A put word writes one cell for a plain byte, none for a newline and three
// for a byte shown as a backslash and two hex digits; a read word reads one cell, none when
// out of range. Leaving the bottom row adds a scroll in which every cell of the screen
// store is rewritten one at a time through its single write port. A new word is taken
// while the previous result still waits in the output register.
`default_nettype none

module text_console_writer_unit import tcw_pkg::*; #(
  parameter int ScreenCols = SCREEN_COLS_DEF,
  parameter int ScreenRows = SCREEN_ROWS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  tcw_item_if.sink     item_i,
  tcw_result_if.source result_o,
  tcw_cfg_if.sink      cfg_i
);

  logic [BYTE_W-1:0] color_q;
  logic              out_valid_q;
  tcw_result_t       out_q;
  tcw_item_t         item;
  tcw_seq_t          seq;
  tcw_result_t       eng_res;
  logic              eng_idle, eng_res_valid, res_taken, start;

  assign item.kind      = tcw_kind_e'(item_i.kind);
  assign item.char_code = item_i.char_code;
  assign item.read_row  = item_i.read_row;
  assign item.read_col  = item_i.read_col;

  assign item_i.ready = eng_idle;
  assign start        = item_i.valid && eng_idle;
  assign cfg_i.ready  = 1'b1;
  assign res_taken    = eng_res_valid && (!out_valid_q || result_o.ready);

  tcw_glyph_encoder u_encoder (
    .char_i (item_i.char_code),
    .seq_o  (seq)
  );

  tcw_engine #(
    .ScreenCols (ScreenCols),
    .ScreenRows (ScreenRows)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .item_i      (item),
    .seq_i       (seq),
    .color_i     (color_q),
    .res_taken_i (res_taken),
    .idle_o      (eng_idle),
    .res_valid_o (eng_res_valid),
    .res_o       (eng_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_q     <= TEXT_COLOR_RESET;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        color_q <= cfg_i.text_color;
      end
      if (res_taken) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_taken) begin
      out_q <= eng_res;
    end
  end

  assign result_o.valid      = out_valid_q;
  assign result_o.cursor_row = out_q.cursor_row;
  assign result_o.cursor_col = out_q.cursor_col;
  assign result_o.cell_glyph = out_q.cell_glyph;
  assign result_o.cell_color = out_q.cell_color;

  // Once a word is taken the engine is busy for at least the next cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_i.valid && item_i.ready |=> !item_i.ready)
    else $error("item taken on two consecutive cycles");

  // A finished result always lands in the output register.
  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_taken |=> result_o.valid)
    else $error("result lost on its way to the output register");

  // The reported cursor always lies on the screen.
  a_cursor_on_screen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid |-> (32'(result_o.cursor_col) < 32'(ScreenCols)) &&
                       (32'(result_o.cursor_row) < 32'(ScreenRows)))
    else $error("cursor reported off screen");

endmodule

`default_nettype wire

>>> verif/text_console_writer_unit_test.sv
`timescale 1ns / 100ps

module text_console_writer_unit_test;
  import tcw_pkg::*;

  localparam int COLS = SCREEN_COLS_DEF;
  localparam int ROWS = SCREEN_ROWS_DEF;
  localparam int QUIET_LIMIT = 10000;
  localparam int PHASES = 6;
  localparam int PHASE_WORDS = 130;
  localparam int MAX_REPORTS = 10;

  logic clk_i;
  logic rst_ni;

  tcw_item_if   item_if ();
  tcw_result_if res_if ();
  tcw_cfg_if    cfg_if ();

  text_console_writer_unit #(
    .ScreenCols(COLS),
    .ScreenRows(ROWS)
  ) uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (item_if.sink),
    .result_o(res_if.source),
    .cfg_i   (cfg_if.sink)
  );

  // Mirror of the screen, the cursor and the colour, plus the cursor reports and
  // cell reads still owed by the block.
  class console_mirror;
    logic [CELL_W-1:0] cells [ROWS*COLS];
    logic [BYTE_W-1:0] color;
    int                cur_row;
    int                cur_col;
    tcw_result_t       owed_q[$];
    int                faults;

    function new();
      foreach (cells[i]) cells[i] = CLEAR_CELL;
      color   = TEXT_COLOR_RESET;
      cur_row = 0;
      cur_col = 0;
      faults  = 0;
    endfunction

    function void set_color(logic [BYTE_W-1:0] c);
      color = c;
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    function logic [CHAR_W-1:0] hex_glyph(logic [3:0] d);
      if (d < 4'd10) return CH_DIGIT_0 + CHAR_W'(d);
      return CH_UPPER_A + CHAR_W'(d - 4'd10);
    endfunction

    // On the bottom row a line feed scrolls everything up and blanks the last row.
    function void line_feed();
      cur_col = 0;
      if (cur_row >= ROWS - 1) begin
        for (int i = 0; i < (ROWS - 1) * COLS; i++) cells[i] = cells[i + COLS];
        for (int i = 0; i < COLS; i++) cells[(ROWS - 1) * COLS + i] = {color, CH_SPACE};
        cur_row = ROWS - 1;
      end else begin
        cur_row++;
      end
    endfunction

    function void place(logic [CHAR_W-1:0] g);
      cells[cur_row * COLS + cur_col] = {color, g};
      cur_col++;
      if (cur_col >= COLS) line_feed();
    endfunction

    function void note_item(tcw_item_t it);
      tcw_result_t       owed;
      logic [CHAR_W-1:0] c;
      bit                plain;
      c = it.char_code;
      owed = '0;
      if (it.kind == KIND_PUT) begin
        plain = (c >= CH_LOWER_A && c <= CH_LOWER_Z) || (c >= CH_UPPER_A && c <= CH_UPPER_Z) ||
                (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) || c == CH_BACKSLASH ||
                c == CH_SPACE || c == CH_QUOTE || c == CH_COLON || c == CH_UNDERSCORE;
        if (c == CH_NEWLINE) begin
          line_feed();
        end else if (plain) begin
          place(c);
        end else begin
          place(CH_BACKSLASH);
          place(hex_glyph(c[7:4]));
          place(hex_glyph(c[3:0]));
        end
      end else if (int'(it.read_row) < ROWS && int'(it.read_col) < COLS) begin
        {owed.cell_color, owed.cell_glyph} = cells[int'(it.read_row) * COLS + int'(it.read_col)];
      end
      owed.cursor_row = cur_row[ROW_W-1:0];
      owed.cursor_col = cur_col[COL_W-1:0];
      owed_q.push_back(owed);
    endfunction

    function void check_result(tcw_result_t got);
      tcw_result_t want;
      if (owed_q.size() == 0) begin
        faults++;
        if (faults <= MAX_REPORTS)
          $display("unexpected word: row %0d col %0d glyph %02h colour %02h",
                   got.cursor_row, got.cursor_col, got.cell_glyph, got.cell_color);
        return;
      end
      want = owed_q.pop_front();
      if (got.cursor_row != want.cursor_row || got.cursor_col != want.cursor_col ||
          got.cell_glyph != want.cell_glyph || got.cell_color != want.cell_color) begin
        faults++;
        if (faults <= MAX_REPORTS)
          $display("mismatch: expected %0d/%0d %02h/%02h, got %0d/%0d %02h/%02h",
                   want.cursor_row, want.cursor_col, want.cell_glyph, want.cell_color,
                   got.cursor_row, got.cursor_col, got.cell_glyph, got.cell_color);
      end
    endfunction
  endclass

  console_mirror mirror;
  bit            steady;
  int            ready_hold;
  int            quiet_cycles;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic int idle_len();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic tcw_item_t put_item(logic [CHAR_W-1:0] c);
    tcw_item_t it;
    it = '0;
    it.kind = KIND_PUT;
    it.char_code = c;
    return it;
  endfunction

  function automatic tcw_item_t read_item(logic [ROW_W-1:0] r, logic [COL_W-1:0] k);
    tcw_item_t it;
    it = '0;
    it.kind = KIND_READ;
    it.read_row = r;
    it.read_col = k;
    return it;
  endfunction

  // Reads mostly land on the screen; puts are a mix of newlines, printable text and
  // arbitrary bytes. Unused fields carry random noise.
  function automatic tcw_item_t random_item(int newline_pct);
    tcw_item_t         it;
    logic [CHAR_W-1:0] marks [5];
    int                pick;
    marks = '{CH_SPACE, CH_QUOTE, CH_COLON, CH_BACKSLASH, CH_UNDERSCORE};
    it.char_code = CHAR_W'($urandom_range(0, 255));
    it.read_row  = ROW_W'($urandom_range(0, 31));
    it.read_col  = COL_W'($urandom_range(0, 127));
    if ($urandom_range(0, 99) < 25) begin
      it.kind = KIND_READ;
      if ($urandom_range(0, 9) < 8) begin
        it.read_row = ROW_W'($urandom_range(0, ROWS - 1));
        it.read_col = COL_W'($urandom_range(0, COLS - 1));
      end
    end else begin
      it.kind = KIND_PUT;
      pick = $urandom_range(0, 99);
      if (pick < newline_pct) begin
        it.char_code = CH_NEWLINE;
      end else if (pick < newline_pct + 45) begin
        case ($urandom_range(0, 3))
          0: it.char_code = CH_LOWER_A + CHAR_W'($urandom_range(0, 25));
          1: it.char_code = CH_UPPER_A + CHAR_W'($urandom_range(0, 25));
          2: it.char_code = CH_DIGIT_0 + CHAR_W'($urandom_range(0, 9));
          default: it.char_code = marks[$urandom_range(0, 4)];
        endcase
      end
    end
    return it;
  endfunction

  task automatic send_item(tcw_item_t it);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      item_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    item_if.valid     <= 1'b1;
    item_if.kind      <= it.kind;
    item_if.char_code <= it.char_code;
    item_if.read_row  <= it.read_row;
    item_if.read_col  <= it.read_col;
    do @(posedge clk_i); while (!item_if.ready);
    mirror.note_item(it);
  endtask

  task automatic write_color(logic [BYTE_W-1:0] c);
    cfg_if.valid      <= 1'b1;
    cfg_if.text_color <= c;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    mirror.set_color(c);
  endtask

  task automatic drain();
    while (mirror.pending() > 0) @(posedge clk_i);
  endtask

  // Result side back-pressure: random stalls unless the phase runs flat out.
  always @(posedge clk_i) begin
    int hold;
    if (ready_hold > 0) begin
      ready_hold--;
      res_if.ready <= 1'b0;
    end else if ($urandom_range(0, 99) < 20) begin
      hold = idle_len();
      res_if.ready <= (hold == 0);
      if (hold > 0) ready_hold = hold - 1;
    end else begin
      res_if.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    tcw_result_t got;
    if (rst_ni && res_if.valid && res_if.ready) begin
      got.cursor_row = res_if.cursor_row;
      got.cursor_col = res_if.cursor_col;
      got.cell_glyph = res_if.cell_glyph;
      got.cell_color = res_if.cell_color;
      mirror.check_result(got);
    end
  end

  // A scroll or the clearing pass after reset keeps the item and result ports quiet,
  // so the limit sits well above the length of either.
  always @(posedge clk_i) begin
    if ((item_if.valid && item_if.ready) || (res_if.valid && res_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    tcw_item_t         directed [$];
    logic [BYTE_W-1:0] colors [PHASES];
    int                newline_pcts [PHASES];
    mirror            = new();
    steady            = 1'b0;
    ready_hold        = 0;
    quiet_cycles      = 0;
    clk_i             = 1'b0;
    rst_ni            = 1'b0;
    item_if.valid     = 1'b0;
    item_if.kind      = KIND_PUT;
    item_if.char_code = '0;
    item_if.read_row  = '0;
    item_if.read_col  = '0;
    res_if.ready      = 1'b0;
    cfg_if.valid      = 1'b0;
    cfg_if.text_color = '0;

    colors       = '{8'h00, 8'hFF, 8'h00, 8'h4F, 8'h00, TEXT_COLOR_RESET};
    colors[2]    = BYTE_W'($urandom_range(0, 255));
    colors[4]    = BYTE_W'($urandom_range(0, 255));
    newline_pcts = '{0, 30, 10, 2, 50, 15};

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Corners of the screen, reads off the edge, every kind of printable byte, a
    // newline and bytes that come out as a backslash and two hex digits.
    directed = '{read_item('0, '0), read_item(ROW_W'(ROWS - 1), COL_W'(COLS - 1)),
                 read_item(5'd31, 7'd127),
                 read_item(ROW_W'(ROWS), '0), read_item('0, COL_W'(COLS)),
                 put_item(CH_LOWER_A), put_item(CH_LOWER_Z), put_item(CH_UPPER_A),
                 put_item(CH_UPPER_Z), put_item(CH_DIGIT_0), put_item(CH_DIGIT_9),
                 put_item(CH_BACKSLASH), put_item(CH_SPACE), put_item(CH_QUOTE),
                 put_item(CH_COLON), put_item(CH_UNDERSCORE), put_item(CH_NEWLINE),
                 put_item(8'h00), put_item(8'hFF), put_item(8'h80), put_item(8'h7F),
                 put_item(8'h09), read_item('0, '0), read_item(5'd1, 7'd0),
                 read_item(5'd1, 7'd5)};
    foreach (directed[i]) send_item(directed[i]);
    item_if.valid <= 1'b0;
    drain();

    for (int p = 0; p < PHASES; p++) begin
      write_color(colors[p]);
      steady = (p == 2);
      for (int n = 0; n < PHASE_WORDS; n++) send_item(random_item(newline_pcts[p]));
      item_if.valid <= 1'b0;
      drain();
    end

    steady = 1'b0;
    repeat (20) @(posedge clk_i);
    if (mirror.faults == 0 && mirror.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
